// ----- hdl/qvr_pkg.sv -----
// ============================================================================
// qvr_pkg
// Shared types and constants for the quaternion vector rotation core.
// ============================================================================
`default_nettype none

package qvr_pkg;

    // Field widths
    localparam int QUAT_W    = 16;  // quaternion component, Q1.14
    localparam int VEC_W     = 16;  // vector component, Q3.12
    localparam int PROD_W    = 2 * QUAT_W;          // exact quaternion product
    localparam int COEF_W    = PROD_W + 2;          // matrix coefficient, Q.28
    localparam int TERM_W    = COEF_W + VEC_W;      // coefficient times component
    localparam int SUM_W     = TERM_W + 2;          // exact sum of three terms
    localparam int FRAC_W    = 28;                  // fraction bits of a coefficient
    localparam int QUO_W     = SUM_W - FRAC_W;      // row sum after scaling
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = QUAT_W;
    localparam int STAGES    = 5;

    localparam logic signed [QUAT_W-1:0] QUAT_ONE  = QUAT_W'(16384);
    localparam logic signed [COEF_W-1:0] ONE_Q28   = COEF_W'(1) <<< FRAC_W;
    localparam logic signed [SUM_W-1:0]  RND_BIAS  = (SUM_W'(1) <<< FRAC_W) - SUM_W'(1);
    localparam logic signed [QUO_W-1:0]  RES_MAX   = QUO_W'(32767);
    localparam logic signed [QUO_W-1:0]  RES_MIN   = -QUO_W'(32768);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUAT_W,
        CFG_QUAT_I,
        CFG_QUAT_J,
        CFG_QUAT_K
    } t_cfg_idx;

    typedef struct packed {
        logic signed [QUAT_W-1:0] w;
        logic signed [QUAT_W-1:0] i;
        logic signed [QUAT_W-1:0] j;
        logic signed [QUAT_W-1:0] k;
    } t_quat;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [VEC_W-1:0] z;
    } t_vec;

    typedef struct packed {
        logic signed [PROD_W-1:0] ii;
        logic signed [PROD_W-1:0] jj;
        logic signed [PROD_W-1:0] kk;
        logic signed [PROD_W-1:0] ij;
        logic signed [PROD_W-1:0] ik;
        logic signed [PROD_W-1:0] jk;
        logic signed [PROD_W-1:0] wi;
        logic signed [PROD_W-1:0] wj;
        logic signed [PROD_W-1:0] wk;
    } t_prod;

    typedef struct packed {
        logic signed [COEF_W-1:0] m00;
        logic signed [COEF_W-1:0] m01;
        logic signed [COEF_W-1:0] m02;
        logic signed [COEF_W-1:0] m10;
        logic signed [COEF_W-1:0] m11;
        logic signed [COEF_W-1:0] m12;
        logic signed [COEF_W-1:0] m20;
        logic signed [COEF_W-1:0] m21;
        logic signed [COEF_W-1:0] m22;
    } t_coef;

    typedef struct packed {
        logic signed [TERM_W-1:0] t00;
        logic signed [TERM_W-1:0] t01;
        logic signed [TERM_W-1:0] t02;
        logic signed [TERM_W-1:0] t10;
        logic signed [TERM_W-1:0] t11;
        logic signed [TERM_W-1:0] t12;
        logic signed [TERM_W-1:0] t20;
        logic signed [TERM_W-1:0] t21;
        logic signed [TERM_W-1:0] t22;
    } t_term;

    typedef struct packed {
        logic signed [SUM_W-1:0] x;
        logic signed [SUM_W-1:0] y;
        logic signed [SUM_W-1:0] z;
    } t_sum;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [VEC_W-1:0] z;
        logic                    clipped;
    } t_rot;

    // Per-stage load enables, stage 1 at the input
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } t_pipe_en;

endpackage

`default_nettype wire

// ----- hdl/qvr_vec_if.sv -----
// ============================================================================
// qvr_vec_if
// Input vector channel: valid/ready handshake with three Q3.12 components.
// ============================================================================
`default_nettype none

interface qvr_vec_if;
    import qvr_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VEC_W-1:0] vec_x;
    logic signed [VEC_W-1:0] vec_y;
    logic signed [VEC_W-1:0] vec_z;

    modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
    modport sink   (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

`default_nettype wire

// ----- hdl/qvr_rot_if.sv -----
// ============================================================================
// qvr_rot_if
// Result channel: valid/ready handshake with the rotated vector and clip flag.
// ============================================================================
`default_nettype none

interface qvr_rot_if;
    import qvr_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VEC_W-1:0] rot_x;
    logic signed [VEC_W-1:0] rot_y;
    logic signed [VEC_W-1:0] rot_z;
    logic                    clipped;

    modport source (output valid, output rot_x, output rot_y, output rot_z,
                    output clipped, input ready);
    modport sink   (input valid, input rot_x, input rot_y, input rot_z,
                    input clipped, output ready);
endinterface

`default_nettype wire

// ----- hdl/quaternion_vector_rotate_core.sv -----
// ============================================================================
// quaternion_vector_rotate_core
// Rotates a stream of Q3.12 vectors by the Q1.14 quaternion held in four
// configuration registers, with toward-zero rounding and 16-bit saturation.
// ============================================================================
//
//   Channel  Dir  Handshake      Payload
//   i_vec    in   valid/ready    vec_x, vec_y, vec_z  (signed 16)
//   o_rot    out  valid/ready    rot_x, rot_y, rot_z (signed 16), clipped
//   i_cfg_*  in   write enable   index 0..3 = quat_w, quat_i, quat_j, quat_k
//
// One vector is taken per cycle unless the input stalls. Five register stages
// (products, coefficients, coefficient multiply, row sum, scale and saturate)
// lie between the beat taken at i_vec and its result at o_rot.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// close up while a result waits at o_rot; the input stalls only once all
// five stages hold a beat.
// Reset empties the pipeline and loads the identity quaternion.
// ============================================================================
`default_nettype none

module quaternion_vector_rotate_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    qvr_vec_if.sink                                i_vec,
    qvr_rot_if.source                              o_rot,
    input  wire logic                              i_cfg_we,
    input  wire logic [qvr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [qvr_pkg::CFG_DAT_W-1:0]     i_cfg_data
);
    import qvr_pkg::*;

    t_quat            r_quat;
    logic [STAGES:1]  r_vld;
    logic [STAGES:1]  w_rdy;
    t_pipe_en         w_en;
    t_vec             w_vec_in;
    t_coef            w_coef;
    t_vec             w_vec2;
    t_sum             w_sum;
    t_rot             w_rot;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat.w <= QUAT_ONE;
            r_quat.i <= '0;
            r_quat.j <= '0;
            r_quat.k <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_QUAT_W: r_quat.w <= i_cfg_data;
                CFG_QUAT_I: r_quat.i <= i_cfg_data;
                CFG_QUAT_J: r_quat.j <= i_cfg_data;
                CFG_QUAT_K: r_quat.k <= i_cfg_data;
                default:    r_quat   <= r_quat;
            endcase
        end
    end

    // Ready chain: a stage advances when empty or when its successor advances
    always_comb begin
        w_rdy[5] = !r_vld[5] || o_rot.ready;
        w_rdy[4] = !r_vld[4] || w_rdy[5];
        w_rdy[3] = !r_vld[3] || w_rdy[4];
        w_rdy[2] = !r_vld[2] || w_rdy[3];
        w_rdy[1] = !r_vld[1] || w_rdy[2];
        w_en.s1  = w_rdy[1];
        w_en.s2  = w_rdy[2];
        w_en.s3  = w_rdy[3];
        w_en.s4  = w_rdy[4];
        w_en.s5  = w_rdy[5];
    end

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[1]) begin
                r_vld[1] <= i_vec.valid;
            end
            if (w_rdy[2]) begin
                r_vld[2] <= r_vld[1];
            end
            if (w_rdy[3]) begin
                r_vld[3] <= r_vld[2];
            end
            if (w_rdy[4]) begin
                r_vld[4] <= r_vld[3];
            end
            if (w_rdy[5]) begin
                r_vld[5] <= r_vld[4];
            end
        end
    end

    assign i_vec.ready = w_rdy[1];
    assign w_vec_in.x  = i_vec.vec_x;
    assign w_vec_in.y  = i_vec.vec_y;
    assign w_vec_in.z  = i_vec.vec_z;

    qvr_coef u_coef (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_quat (r_quat),
        .i_vec  (w_vec_in),
        .o_coef (w_coef),
        .o_vec  (w_vec2)
    );

    qvr_mac u_mac (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_coef (w_coef),
        .i_vec  (w_vec2),
        .o_sum  (w_sum)
    );

    qvr_fin u_fin (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_sum  (w_sum),
        .o_rot  (w_rot)
    );

    // Drive the result beat
    assign o_rot.valid   = r_vld[5];
    assign o_rot.rot_x   = w_rot.x;
    assign o_rot.rot_y   = w_rot.y;
    assign o_rot.rot_z   = w_rot.z;
    assign o_rot.clipped = w_rot.clipped;

endmodule

`default_nettype wire

// ----- hdl/qvr_coef.sv -----
// ============================================================================
// qvr_coef
// Stages 1 and 2: quaternion component products, then the nine rotation
// matrix coefficients in Q.28. The vector rides along with its coefficients.
// ============================================================================
`default_nettype none

module qvr_coef (
    input  wire logic           i_clk,
    input  wire qvr_pkg::t_pipe_en i_en,
    input  wire qvr_pkg::t_quat i_quat,
    input  wire qvr_pkg::t_vec  i_vec,
    output qvr_pkg::t_coef      o_coef,
    output qvr_pkg::t_vec       o_vec
);
    import qvr_pkg::*;

    t_prod r_prod, n_prod;
    t_vec  r_vec1;
    t_coef r_coef, n_coef;
    t_vec  r_vec2;

    // Stage 1: nine exact 16x16 products
    always_comb begin
        n_prod.ii = PROD_W'(i_quat.i) * PROD_W'(i_quat.i);
        n_prod.jj = PROD_W'(i_quat.j) * PROD_W'(i_quat.j);
        n_prod.kk = PROD_W'(i_quat.k) * PROD_W'(i_quat.k);
        n_prod.ij = PROD_W'(i_quat.i) * PROD_W'(i_quat.j);
        n_prod.ik = PROD_W'(i_quat.i) * PROD_W'(i_quat.k);
        n_prod.jk = PROD_W'(i_quat.j) * PROD_W'(i_quat.k);
        n_prod.wi = PROD_W'(i_quat.w) * PROD_W'(i_quat.i);
        n_prod.wj = PROD_W'(i_quat.w) * PROD_W'(i_quat.j);
        n_prod.wk = PROD_W'(i_quat.w) * PROD_W'(i_quat.k);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_prod <= n_prod;
            r_vec1 <= i_vec;
        end
    end

    // Stage 2: diagonal is one minus twice a sum of squares, the rest twice a sum or difference
    always_comb begin
        n_coef.m00 = ONE_Q28 - ((COEF_W'(r_prod.jj) + COEF_W'(r_prod.kk)) <<< 1);
        n_coef.m01 = (COEF_W'(r_prod.ij) - COEF_W'(r_prod.wk)) <<< 1;
        n_coef.m02 = (COEF_W'(r_prod.ik) + COEF_W'(r_prod.wj)) <<< 1;
        n_coef.m10 = (COEF_W'(r_prod.ij) + COEF_W'(r_prod.wk)) <<< 1;
        n_coef.m11 = ONE_Q28 - ((COEF_W'(r_prod.ii) + COEF_W'(r_prod.kk)) <<< 1);
        n_coef.m12 = (COEF_W'(r_prod.jk) - COEF_W'(r_prod.wi)) <<< 1;
        n_coef.m20 = (COEF_W'(r_prod.ik) - COEF_W'(r_prod.wj)) <<< 1;
        n_coef.m21 = (COEF_W'(r_prod.jk) + COEF_W'(r_prod.wi)) <<< 1;
        n_coef.m22 = ONE_Q28 - ((COEF_W'(r_prod.ii) + COEF_W'(r_prod.jj)) <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_coef <= n_coef;
            r_vec2 <= r_vec1;
        end
    end

    assign o_coef = r_coef;
    assign o_vec  = r_vec2;

endmodule

`default_nettype wire

// ----- hdl/qvr_mac.sv -----
// ============================================================================
// qvr_mac
// Stages 3 and 4: nine coefficient-by-component products, then the three
// exact row sums.
// ============================================================================
`default_nettype none

module qvr_mac (
    input  wire logic              i_clk,
    input  wire qvr_pkg::t_pipe_en i_en,
    input  wire qvr_pkg::t_coef    i_coef,
    input  wire qvr_pkg::t_vec     i_vec,
    output qvr_pkg::t_sum          o_sum
);
    import qvr_pkg::*;

    t_term r_term, n_term;
    t_sum  r_sum, n_sum;

    // Stage 3: 34x16 products, exact
    always_comb begin
        n_term.t00 = TERM_W'(i_coef.m00) * TERM_W'(i_vec.x);
        n_term.t01 = TERM_W'(i_coef.m01) * TERM_W'(i_vec.y);
        n_term.t02 = TERM_W'(i_coef.m02) * TERM_W'(i_vec.z);
        n_term.t10 = TERM_W'(i_coef.m10) * TERM_W'(i_vec.x);
        n_term.t11 = TERM_W'(i_coef.m11) * TERM_W'(i_vec.y);
        n_term.t12 = TERM_W'(i_coef.m12) * TERM_W'(i_vec.z);
        n_term.t20 = TERM_W'(i_coef.m20) * TERM_W'(i_vec.x);
        n_term.t21 = TERM_W'(i_coef.m21) * TERM_W'(i_vec.y);
        n_term.t22 = TERM_W'(i_coef.m22) * TERM_W'(i_vec.z);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_term <= n_term;
        end
    end

    // Stage 4: row sums with two guard bits
    always_comb begin
        n_sum.x = SUM_W'(r_term.t00) + SUM_W'(r_term.t01) + SUM_W'(r_term.t02);
        n_sum.y = SUM_W'(r_term.t10) + SUM_W'(r_term.t11) + SUM_W'(r_term.t12);
        n_sum.z = SUM_W'(r_term.t20) + SUM_W'(r_term.t21) + SUM_W'(r_term.t22);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

`default_nettype wire

// ----- hdl/qvr_fin.sv -----
// ============================================================================
// qvr_fin
// Stage 5: scale each row sum by 2^-28 toward zero, saturate to 16 bits and
// hold the result beat in the output register.
// ============================================================================
`default_nettype none

module qvr_fin (
    input  wire logic              i_clk,
    input  wire qvr_pkg::t_pipe_en i_en,
    input  wire qvr_pkg::t_sum     i_sum,
    output qvr_pkg::t_rot          o_rot
);
    import qvr_pkg::*;

    t_rot r_rot, n_rot;
    logic [VEC_W:0] w_fx, w_fy, w_fz;

    // Returns {saturated, value}
    function automatic logic [VEC_W:0] scale_sat(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] b;
        logic signed [QUO_W-1:0] q;
        logic [VEC_W:0]          r;
        b = s + (s[SUM_W-1] ? RND_BIAS : '0);
        q = b[SUM_W-1:FRAC_W];
        if (q > RES_MAX) begin
            r = {1'b1, RES_MAX[VEC_W-1:0]};
        end else if (q < RES_MIN) begin
            r = {1'b1, RES_MIN[VEC_W-1:0]};
        end else begin
            r = {1'b0, q[VEC_W-1:0]};
        end
        return r;
    endfunction

    // Round toward zero and clamp each component
    always_comb begin
        w_fx          = scale_sat(i_sum.x);
        w_fy          = scale_sat(i_sum.y);
        w_fz          = scale_sat(i_sum.z);
        n_rot.x       = w_fx[VEC_W-1:0];
        n_rot.y       = w_fy[VEC_W-1:0];
        n_rot.z       = w_fz[VEC_W-1:0];
        n_rot.clipped = w_fx[VEC_W] | w_fy[VEC_W] | w_fz[VEC_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s5) begin
            r_rot <= n_rot;
        end
    end

    assign o_rot = r_rot;

endmodule

`default_nettype wire

// ----- hdl/qvr_chk.sv -----
// ============================================================================
// qvr_chk
// Port-level checks for the rotation core, bound to the top level.
// ============================================================================
`default_nettype none

module qvr_chk (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_ready,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic signed [15:0] i_rot_x,
    input  wire logic signed [15:0] i_rot_y,
    input  wire logic signed [15:0] i_rot_z,
    input  wire logic        i_clipped
);

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat valid right after reset");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_rot_x) && $stable(i_rot_y)
            && $stable(i_rot_z) && $stable(i_clipped))
        else $error("stalled result beat changed");

    // A draining output frees the input side
    a_in_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("input stalled while output drains");

    // A clipped beat carries at least one rail value
    a_clip_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_clipped |->
            (i_rot_x == 16'sh7FFF) || (i_rot_x == -16'sh8000) ||
            (i_rot_y == 16'sh7FFF) || (i_rot_y == -16'sh8000) ||
            (i_rot_z == 16'sh7FFF) || (i_rot_z == -16'sh8000))
        else $error("clip flag set without a saturated component");

endmodule

bind quaternion_vector_rotate_core qvr_chk u_qvr_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_vec.ready),
    .i_out_valid (o_rot.valid),
    .i_out_ready (o_rot.ready),
    .i_rot_x     (o_rot.rot_x),
    .i_rot_y     (o_rot.rot_y),
    .i_rot_z     (o_rot.rot_z),
    .i_clipped   (o_rot.clipped)
);

`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Streams Q3.12 vectors through quaternion_vector_rotate_core and checks
// every rotated beat against an in-bench fixed-point rotation, across
// quaternion settings from identity to full-scale non-unit values.
// ============================================================================

module testbench;
    import qvr_pkg::*;

    localparam int IDLE_LIMIT  = 1000;  // cycles with no beat on either side
    localparam int DRAIN_WAIT  = 20;    // settle time after the last result
    localparam int PRINT_MAX   = 40;
    localparam int HOLD_AT     = 300;   // input beats before the output hold-off
    localparam int HOLD_CYCLES = 80;
    localparam int QUIET_LO    = 600;   // no random gaps or stalls on either side in this window
    localparam int QUIET_HI    = 800;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_ITEMS = 130;
    localparam int DIR_ITEMS   = 8;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx  = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    qvr_vec_if vec_if ();
    qvr_rot_if rot_if ();

    quaternion_vector_rotate_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vec      (vec_if),
        .o_rot      (rot_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Quaternion as last written, starts at the reset identity
    t_quat quat_cfg = '{w: QUAT_ONE, i: '0, j: '0, k: '0};

    t_vec vec_todo_q[$];
    t_rot rot_pending_q[$];

    int n_vec_beats = 0;
    int n_err       = 0;
    int idle_cycles = 0;

    logic quiet;
    assign quiet = (n_vec_beats >= QUIET_LO) && (n_vec_beats < QUIET_HI);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Scale an exact Q.40 row sum to Q3.12 toward zero, then clamp
    function automatic logic [VEC_W-1:0] scale_sat(input longint s, inout logic clip);
        longint r;
        r = s / (longint'(1) <<< FRAC_W);
        if (r > 32767) begin
            r = 32767;
            clip = 1'b1;
        end else if (r < -32768) begin
            r = -32768;
            clip = 1'b1;
        end
        return VEC_W'(r);
    endfunction

    function automatic t_rot rotate_vec(input t_quat q, input t_vec v);
        longint w, i, j, k, x, y, z, one;
        longint ii, jj, kk, ij, ik, jk, wi, wj, wk;
        longint m00, m01, m02, m10, m11, m12, m20, m21, m22;
        logic   clip;
        t_rot   r;
        w = $signed(q.w);
        i = $signed(q.i);
        j = $signed(q.j);
        k = $signed(q.k);
        x = $signed(v.x);
        y = $signed(v.y);
        z = $signed(v.z);
        one = longint'(1) <<< FRAC_W;
        ii = i * i; jj = j * j; kk = k * k;
        ij = i * j; ik = i * k; jk = j * k;
        wi = w * i; wj = w * j; wk = w * k;
        m00 = one - 2 * (jj + kk);
        m01 = 2 * (ij - wk);
        m02 = 2 * (ik + wj);
        m10 = 2 * (ij + wk);
        m11 = one - 2 * (ii + kk);
        m12 = 2 * (jk - wi);
        m20 = 2 * (ik - wj);
        m21 = 2 * (jk + wi);
        m22 = one - 2 * (ii + jj);
        clip = 1'b0;
        r.x = scale_sat(m00 * x + m01 * y + m02 * z, clip);
        r.y = scale_sat(m10 * x + m11 * y + m12 * z, clip);
        r.z = scale_sat(m20 * x + m21 * y + m22 * z, clip);
        r.clipped = clip;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    task automatic report(input string msg);
        n_err++;
        if (n_err <= PRINT_MAX) begin
            $display("%0t mismatch: %s", $time, msg);
        end
    endtask

    function automatic logic [VEC_W-1:0] extreme_comp();
        case ($urandom_range(0, 4))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'h0001;
        endcase
    endfunction

    function automatic t_vec directed_vec(input int n);
        case (n)
            0: return '{x: 16'h0000, y: 16'h0000, z: 16'h0000};
            1: return '{x: 16'h7FFF, y: 16'h7FFF, z: 16'h7FFF};
            2: return '{x: 16'h8000, y: 16'h8000, z: 16'h8000};
            3: return '{x: 16'h7FFF, y: 16'h8000, z: 16'h0001};
            4: return '{x: 16'h8000, y: 16'hFFFF, z: 16'h7FFF};
            5: return '{x: 16'h5555, y: 16'hAAAA, z: 16'h5555};
            6: return '{x: 16'hAAAA, y: 16'h5555, z: 16'hAAAA};
            default: return '{x: 16'h1000, y: 16'h0000, z: 16'h0000};
        endcase
    endfunction

    // Mostly full-range, some short vectors, some built from extremes
    function automatic t_vec rand_vec();
        t_vec v;
        case ($urandom_range(0, 9))
            7, 8: begin
                v.x = VEC_W'(int'($urandom_range(0, 8192)) - 4096);
                v.y = VEC_W'(int'($urandom_range(0, 8192)) - 4096);
                v.z = VEC_W'(int'($urandom_range(0, 8192)) - 4096);
            end
            9: begin
                v.x = extreme_comp();
                v.y = extreme_comp();
                v.z = extreme_comp();
            end
            default: begin
                v.x = VEC_W'($urandom);
                v.y = VEC_W'($urandom);
                v.z = VEC_W'($urandom);
            end
        endcase
        return v;
    endfunction

    // Quaternion for one random phase: unit length unless the phase asks
    // for an extreme, zero or raw bit pattern
    function automatic t_quat phase_quat(input int p);
        real   a[4];
        real   mag;
        t_quat q;
        case (p)
            2: q = '{w: QUAT_ONE, i: QUAT_ONE, j: QUAT_ONE, k: QUAT_ONE};
            5: q = '{w: -QUAT_ONE, i: -QUAT_ONE, j: -QUAT_ONE, k: -QUAT_ONE};
            7: q = '0;
            4, 8: q = '{w: QUAT_W'($urandom), i: QUAT_W'($urandom),
                        j: QUAT_W'($urandom), k: QUAT_W'($urandom)};
            default: begin
                mag = 0.0;
                while (mag < 0.1) begin
                    for (int n = 0; n < 4; n++) begin
                        a[n] = (real'(int'($urandom_range(0, 65536))) - 32768.0) / 32768.0;
                    end
                    mag = $sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2] + a[3] * a[3]);
                end
                q.w = QUAT_W'($rtoi(a[0] / mag * 16384.0));
                q.i = QUAT_W'($rtoi(a[1] / mag * 16384.0));
                q.j = QUAT_W'($rtoi(a[2] / mag * 16384.0));
                q.k = QUAT_W'($rtoi(a[3] / mag * 16384.0));
            end
        endcase
        return q;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
    endtask

    // Load a quaternion; a write to an unused index goes first and must be ignored
    task automatic set_quat(input t_quat q);
        write_reg(CFG_IDX_W'($urandom_range(int'(CFG_QUAT_K) + 1, 2 ** CFG_IDX_W - 1)),
                  CFG_DAT_W'($urandom));
        write_reg(CFG_QUAT_W, q.w);
        write_reg(CFG_QUAT_I, q.i);
        write_reg(CFG_QUAT_J, q.j);
        write_reg(CFG_QUAT_K, q.k);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        quat_cfg = q;
        @(negedge i_clk);
    endtask

    // Hold until every queued vector is taken and every result is back
    task automatic wait_drained();
        @(negedge i_clk);
        while (vec_todo_q.size() != 0 || vec_if.valid || rot_pending_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Input driver: one beat per handshake, random gaps
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_vec
        t_vec nxt;
        if (!i_rst_n) begin
            vec_if.valid <= 1'b0;
        end else begin
            if (vec_if.valid && vec_if.ready) begin
                rot_pending_q.push_back(rotate_vec(quat_cfg,
                    '{x: vec_if.vec_x, y: vec_if.vec_y, z: vec_if.vec_z}));
                n_vec_beats <= n_vec_beats + 1;
            end
            if (!vec_if.valid || vec_if.ready) begin
                if (vec_todo_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 10)) begin
                    nxt = vec_todo_q.pop_front();
                    vec_if.valid <= 1'b1;
                    vec_if.vec_x <= nxt.x;
                    vec_if.vec_y <= nxt.y;
                    vec_if.vec_z <= nxt.z;
                end else begin
                    vec_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: check each beat, drive ready with stalls and one hold-off
    // ------------------------------------------------------------------------
    int   hold_left = 0;
    logic hold_done = 1'b0;

    always @(posedge i_clk) begin : check_rot
        t_rot got;
        t_rot want;
        if (!i_rst_n) begin
            rot_if.ready <= 1'b0;
        end else begin
            if (rot_if.valid && rot_if.ready) begin
                got = '{x: rot_if.rot_x, y: rot_if.rot_y, z: rot_if.rot_z,
                        clipped: rot_if.clipped};
                if (rot_pending_q.size() == 0) begin
                    report($sformatf("result (%0d, %0d, %0d, clip %0b) with none pending",
                                     got.x, got.y, got.z, got.clipped));
                end else begin
                    want = rot_pending_q.pop_front();
                    if (got !== want) begin
                        report($sformatf("got (%0d, %0d, %0d, clip %0b) want (%0d, %0d, %0d, clip %0b)",
                                         got.x, got.y, got.z, got.clipped,
                                         want.x, want.y, want.z, want.clipped));
                    end
                end
            end
            // Long hold-off lets the pipeline fill and back up into the input
            if (hold_left != 0) begin
                hold_left    <= hold_left - 1;
                rot_if.ready <= 1'b0;
            end else if (!hold_done && n_vec_beats >= HOLD_AT) begin
                hold_left    <= HOLD_CYCLES;
                hold_done    <= 1'b1;
                rot_if.ready <= 1'b0;
            end else begin
                rot_if.ready <= quiet || ($urandom_range(0, 99) >= 10);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: stop if no beat moves on either channel for too long
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (vec_if.valid && vec_if.ready) || (rot_if.valid && rot_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: directed phases, then random quaternion phases
    // ------------------------------------------------------------------------
    initial begin : run_seq
        vec_if.valid = 1'b0;
        vec_if.vec_x = '0;
        vec_if.vec_y = '0;
        vec_if.vec_z = '0;
        rot_if.ready = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset identity quaternion
        for (int n = 0; n < DIR_ITEMS; n++) vec_todo_q.push_back(directed_vec(n));
        wait_drained();

        // Full-scale non-unit quaternion at the limits of the Q1.14 range: saturates
        set_quat('{w: 16'h7FFF, i: 16'h8000, j: 16'h7FFF, k: 16'h8000});
        for (int n = 0; n < DIR_ITEMS; n++) vec_todo_q.push_back(directed_vec(n));
        wait_drained();

        // Quarter turn about z
        set_quat('{w: 16'sd11585, i: '0, j: '0, k: 16'sd11585});
        for (int n = 0; n < DIR_ITEMS; n++) vec_todo_q.push_back(directed_vec(n));
        wait_drained();

        for (int p = 0; p < RAND_PHASES; p++) begin
            set_quat(phase_quat(p));
            for (int n = 0; n < PHASE_ITEMS; n++) vec_todo_q.push_back(rand_vec());
            wait_drained();
        end

        // Catch any stray result after the last expected one
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (rot_pending_q.size() != 0) begin
            report($sformatf("%0d results never arrived", rot_pending_q.size()));
        end

        if (n_err == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
